/* rtl/plcs_pkg.sv */
`timescale 1ns / 1ps
package plcs_pkg;

	localparam int MAX_KEYS = 64;
	localparam int KEY_AW   = $clog2(MAX_KEYS);
	localparam int VALUE_W  = 32;
	localparam int STAMP_W  = 17;
	localparam int KC_W     = 7;
	localparam int DIM_W    = 2;

	// Widths of the quotient magnitude, product and divider step counter of one lerp lane.
	localparam int MAG_W  = VALUE_W + 1;
	localparam int PROD_W = MAG_W + STAMP_W;
	localparam int QCNT_W = $clog2(MAG_W);

	localparam logic [STAMP_W-1:0] STAMP_ONE = STAMP_W'(65536);

	localparam logic [1:0] ACT_WRITE   = 2'd0;
	localparam logic [1:0] ACT_SAMPLE  = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_TIME  = 2'd1;
	localparam logic [1:0] ERR_DEGEN = 2'd2;
	localparam logic [1:0] ERR_PAST  = 2'd3;

	localparam logic REG_KEY_COUNT = 1'b0;
	localparam logic REG_DIM_MODE  = 1'b1;

	localparam logic [DIM_W-1:0] DIM_THREE = 2'd3;

	localparam logic [KC_W-1:0] KC_RESET  = 7'd2;
	localparam logic [DIM_W-1:0] DIM_RESET = 2'd1;

	typedef struct packed {
		logic [STAMP_W-1:0]        stamp;
		logic signed [VALUE_W-1:0] x;
		logic signed [VALUE_W-1:0] y;
		logic signed [VALUE_W-1:0] z;
	} key_t;

endpackage

/* rtl/plcs_key_mem.sv */
`timescale 1ns / 1ps
module plcs_key_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [plcs_pkg::KEY_AW-1:0] wa,
	input  plcs_pkg::key_t            wd,
	input  logic [plcs_pkg::KEY_AW-1:0] ra0,
	input  logic [plcs_pkg::KEY_AW-1:0] ra1,
	output plcs_pkg::key_t            rd0,
	output plcs_pkg::key_t            rd1
);
	import plcs_pkg::*;

	// One write port and two registered read ports.
	key_t mem [MAX_KEYS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rd0 <= mem[ra0];
		rd1 <= mem[ra1];
	end

endmodule

/* rtl/plcs_lerp_lane.sv */
`timescale 1ns / 1ps
module plcs_lerp_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               go,
	input  logic signed [plcs_pkg::VALUE_W-1:0] v0,
	input  logic signed [plcs_pkg::VALUE_W-1:0] v1,
	input  logic [plcs_pkg::STAMP_W-1:0]        num,
	input  logic [plcs_pkg::STAMP_W-1:0]        den,
	output logic signed [plcs_pkg::VALUE_W-1:0] res,
	output logic                               done
);
	import plcs_pkg::*;

	typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lane_state_t;

	lane_state_t               state_q;
	logic signed [VALUE_W-1:0] v0_q;
	logic                      neg_q;
	logic [MAG_W-1:0]          mag_q;
	logic [STAMP_W-1:0]        num_q;
	logic [STAMP_W-1:0]        den_q;
	logic [STAMP_W-1:0]        rem_q;
	logic [MAG_W-1:0]          quo_q;
	logic [QCNT_W-1:0]         cnt_q;
	logic signed [VALUE_W-1:0] res_q;
	logic                      done_q;

	logic [MAG_W-1:0]   dv;
	logic [MAG_W-1:0]   mag;
	logic [PROD_W-1:0]  prod;
	logic [STAMP_W:0]   shifted;
	logic [STAMP_W:0]   diff;
	logic               ge;
	logic [MAG_W-1:0]   sum;

	always_comb begin
		dv      = {v1[VALUE_W-1], v1} - {v0[VALUE_W-1], v0};
		mag     = dv[MAG_W-1] ? (~dv + MAG_W'(1)) : dv;
		prod    = PROD_W'(mag_q) * PROD_W'(num_q);
		shifted = {rem_q, quo_q[MAG_W-1]};
		ge      = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
		sum     = neg_q ? ({v0_q[VALUE_W-1], v0_q} - quo_q)
		                : ({v0_q[VALUE_W-1], v0_q} + quo_q);
	end

	// Restoring division of mag*num by den, one quotient bit per cycle.
	// The high part of the product is already below den, so only the
	// quotient's MAG_W bits need a step each.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			v0_q    <= '0;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			num_q   <= '0;
			den_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (go) begin
						v0_q    <= v0;
						neg_q   <= dv[MAG_W-1];
						mag_q   <= mag;
						num_q   <= num;
						den_q   <= den;
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					rem_q   <= prod[PROD_W-1:MAG_W];
					quo_q   <= prod[MAG_W-1:0];
					cnt_q   <= '0;
					state_q <= L_DIV;
				end
				L_DIV: begin
					rem_q <= ge ? diff[STAMP_W-1:0] : shifted[STAMP_W-1:0];
					quo_q <= {quo_q[MAG_W-2:0], ge};
					cnt_q <= cnt_q + QCNT_W'(1);
					if (cnt_q == QCNT_W'(MAG_W - 1)) begin
						state_q <= L_FIN;
					end
				end
				L_FIN: begin
					res_q   <= sum[VALUE_W-1:0];
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule

/* rtl/piecewise_linear_curve_sampler.sv */
`timescale 1ns / 1ps
// Channel   Handshake                       Payload
// -------   -----------------------------   ----------------------------------------------
// command   start, busy (accept: start&~busy) action, key_slot, key_stamp, key_value_x/y/z,
//                                           sample_time
// result    done (one-cycle strobe)         out_x, out_y, out_z, segment, error_code
// config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// Writes and restarts finish in the cycle of their transfer. A sample holds busy
// high while the cursor steps over keys, with one more step when it restarts at
// key 0, then while the lanes divide, and shows its result in the cycle after;
// a degenerate segment skips the lanes. Each search step waits for a registered
// key read; the rest is the 33-step bit-serial divider per lane.
// Reset is asynchronous and active low; it clears the cursor and the registers but
// not the key memory. The receiver cannot stall: each result shows for one cycle.
module piecewise_linear_curve_sampler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         action,
	input  logic [5:0]                         key_slot,
	input  logic [plcs_pkg::STAMP_W-1:0]        key_stamp,
	input  logic signed [plcs_pkg::VALUE_W-1:0] key_value_x,
	input  logic signed [plcs_pkg::VALUE_W-1:0] key_value_y,
	input  logic signed [plcs_pkg::VALUE_W-1:0] key_value_z,
	input  logic [plcs_pkg::STAMP_W-1:0]        sample_time,
	output logic                               done,
	output logic signed [plcs_pkg::VALUE_W-1:0] out_x,
	output logic signed [plcs_pkg::VALUE_W-1:0] out_y,
	output logic signed [plcs_pkg::VALUE_W-1:0] out_z,
	output logic [5:0]                         segment,
	output logic [1:0]                         error_code,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import plcs_pkg::*;

	// S_CHECK sees the first read at the starting cursor; S_SEARCH walks
	// forward; S_WAIT waits for the lerp lanes.
	typedef enum logic [1:0] {S_IDLE, S_CHECK, S_SEARCH, S_WAIT} state_t;

	state_t                    state_q;
	logic [KEY_AW-1:0]         cur_q;
	logic [STAMP_W-1:0]        t_q;
	logic                      bad_q;
	logic [KC_W-1:0]           key_count_q;
	logic [DIM_W-1:0]          dim_mode_q;
	logic                      done_q;
	logic signed [VALUE_W-1:0] out_x_q;
	logic signed [VALUE_W-1:0] out_y_q;
	logic signed [VALUE_W-1:0] out_z_q;
	logic [5:0]                seg_q;
	logic [1:0]                err_q;

	logic                      accept;
	logic                      cfg_wr;
	logic                      three_d;
	logic [KC_W-1:0]           kc;
	logic [KEY_AW-1:0]         last;
	logic [KEY_AW-1:0]         c_start;
	logic                      samp_bad;
	logic [STAMP_W-1:0]        t_cl;
	logic                      searching;
	logic                      restart;
	logic                      step_hit;
	logic                      found;
	logic                      degen;
	logic                      ascending;
	logic [STAMP_W-1:0]        lo;
	logic [STAMP_W-1:0]        hi;
	logic [STAMP_W-1:0]        te;
	logic                      clamp_bad;
	logic [STAMP_W-1:0]        num;
	logic [STAMP_W-1:0]        den;
	logic [1:0]                err_next;
	logic                      lane_go;

	logic                      mem_we;
	key_t                      mem_wd;
	logic [KEY_AW-1:0]         ra0;
	logic [KEY_AW-1:0]         ra1;
	key_t                      rd0;
	key_t                      rd1;

	logic signed [VALUE_W-1:0] res_x;
	logic signed [VALUE_W-1:0] res_y;
	logic signed [VALUE_W-1:0] res_z;
	logic                      done_x;
	logic                      done_y;
	logic                      done_z;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign three_d = (dim_mode_q == DIM_THREE);

	always_comb begin
		case (paddr[2])
			REG_KEY_COUNT: prdata = 32'(key_count_q);
			REG_DIM_MODE:  prdata = 32'(dim_mode_q);
			default:       prdata = '0;
		endcase
	end

	// Key writes go straight into the memory in the cycle of their transfer.
	assign mem_we = accept && (action == ACT_WRITE) && (7'(key_slot) < KC_W'(MAX_KEYS));
	assign mem_wd = '{stamp: key_stamp, x: key_value_x, y: key_value_y, z: key_value_z};

	always_comb begin
		// Key count is clamped into the table's range; last is the highest
		// segment start.
		if (key_count_q < KC_W'(2)) begin
			kc = KC_W'(2);
		end else if (key_count_q > KC_W'(MAX_KEYS)) begin
			kc = KC_W'(MAX_KEYS);
		end else begin
			kc = key_count_q;
		end
		last = KEY_AW'(kc - KC_W'(2));

		c_start  = (cur_q > last) ? last : cur_q;
		samp_bad = sample_time > STAMP_ONE;
		t_cl     = samp_bad ? STAMP_ONE : sample_time;

		// A search step compares the next key's time against the sample time.
		// In the first check, a current key later than the time sends the
		// cursor back to key 0.
		searching = (state_q == S_CHECK) || (state_q == S_SEARCH);
		restart   = (state_q == S_CHECK) && (rd0.stamp > t_q);
		step_hit  = rd1.stamp >= t_q;
		found     = searching && !restart && (step_hit || (cur_q == last));

		if (state_q == S_IDLE) begin
			ra0 = c_start;
			ra1 = c_start + KEY_AW'(1);
		end else if (restart) begin
			ra0 = '0;
			ra1 = KEY_AW'(1);
		end else begin
			ra0 = cur_q + KEY_AW'(1);
			ra1 = cur_q + KEY_AW'(2);
		end

		// Segment setup: the time is clamped into the segment, which may run
		// backward in time when keys are out of order.
		degen     = rd0.stamp == rd1.stamp;
		ascending = rd0.stamp < rd1.stamp;
		lo        = ascending ? rd0.stamp : rd1.stamp;
		hi        = ascending ? rd1.stamp : rd0.stamp;
		clamp_bad = 1'b0;
		te        = t_q;
		if (t_q < lo) begin
			te        = lo;
			clamp_bad = !degen;
		end else if (t_q > hi) begin
			te        = hi;
			clamp_bad = !degen;
		end
		den = hi - lo;
		num = ascending ? (te - rd0.stamp) : (rd0.stamp - te);

		if (!step_hit) begin
			err_next = ERR_PAST;
		end else if (bad_q || clamp_bad) begin
			err_next = ERR_TIME;
		end else if (degen) begin
			err_next = ERR_DEGEN;
		end else begin
			err_next = ERR_OK;
		end

		lane_go = found && !degen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= KC_RESET;
			dim_mode_q  <= DIM_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_KEY_COUNT: key_count_q <= pwdata[KC_W-1:0];
				REG_DIM_MODE:  dim_mode_q  <= pwdata[DIM_W-1:0];
				default:       key_count_q <= key_count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			t_q     <= '0;
			bad_q   <= 1'b0;
			done_q  <= 1'b0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_z_q <= '0;
			seg_q   <= '0;
			err_q   <= ERR_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_SAMPLE: begin
								t_q     <= t_cl;
								bad_q   <= samp_bad;
								cur_q   <= c_start;
								state_q <= S_CHECK;
							end
							ACT_RESTART: begin
								cur_q <= '0;
							end
							default: begin
								cur_q <= cur_q;
							end
						endcase
					end
				end
				S_CHECK, S_SEARCH: begin
					if (restart) begin
						cur_q   <= '0;
						state_q <= S_SEARCH;
					end else if (found) begin
						seg_q <= 6'(cur_q);
						err_q <= err_next;
						if (degen) begin
							out_x_q <= rd0.x;
							out_y_q <= three_d ? rd0.y : '0;
							out_z_q <= three_d ? rd0.z : '0;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_WAIT;
						end
					end else begin
						cur_q   <= cur_q + KEY_AW'(1);
						state_q <= S_SEARCH;
					end
				end
				S_WAIT: begin
					if (done_x) begin
						out_x_q <= res_x;
						out_y_q <= three_d ? res_y : '0;
						out_z_q <= three_d ? res_z : '0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	plcs_key_mem u_key_mem (
		.clk (clk),
		.we  (mem_we),
		.wa  (KEY_AW'(key_slot)),
		.wd  (mem_wd),
		.ra0 (ra0),
		.ra1 (ra1),
		.rd0 (rd0),
		.rd1 (rd1)
	);

	// The three lanes run in lockstep; lane x's strobe stands for all.
	plcs_lerp_lane u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (lane_go),
		.v0     (rd0.x),
		.v1     (rd1.x),
		.num    (num),
		.den    (den),
		.res    (res_x),
		.done   (done_x)
	);

	plcs_lerp_lane u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (lane_go),
		.v0     (rd0.y),
		.v1     (rd1.y),
		.num    (num),
		.den    (den),
		.res    (res_y),
		.done   (done_y)
	);

	plcs_lerp_lane u_lane_z (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (lane_go),
		.v0     (rd0.z),
		.v1     (rd1.z),
		.num    (num),
		.den    (den),
		.res    (res_z),
		.done   (done_z)
	);

	assign done       = done_q && (done_y || !done_y) && (done_z || !done_z);
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign out_z      = out_z_q;
	assign segment    = seg_q;
	assign error_code = err_q;

endmodule

/* tb/plcs_curve_checker.sv */
`timescale 1ns / 1ps
module plcs_curve_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic [1:0]                          action,
	input  logic [5:0]                          key_slot,
	input  logic [plcs_pkg::STAMP_W-1:0]        key_stamp,
	input  logic signed [plcs_pkg::VALUE_W-1:0] key_value_x,
	input  logic signed [plcs_pkg::VALUE_W-1:0] key_value_y,
	input  logic signed [plcs_pkg::VALUE_W-1:0] key_value_z,
	input  logic [plcs_pkg::STAMP_W-1:0]        sample_time,
	input  logic                                done,
	input  logic signed [plcs_pkg::VALUE_W-1:0] out_x,
	input  logic signed [plcs_pkg::VALUE_W-1:0] out_y,
	input  logic signed [plcs_pkg::VALUE_W-1:0] out_z,
	input  logic [5:0]                          segment,
	input  logic [1:0]                          error_code,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output int                                  outstanding,
	output int                                  failures
);
	import plcs_pkg::*;

	localparam logic [2:0] ADDR_KEY_COUNT = {REG_KEY_COUNT, 2'b00};
	localparam logic [2:0] ADDR_DIM_MODE  = {REG_DIM_MODE, 2'b00};

	typedef struct packed {
		logic signed [VALUE_W-1:0] x;
		logic signed [VALUE_W-1:0] y;
		logic signed [VALUE_W-1:0] z;
		logic [5:0]                seg;
		logic [1:0]                err;
	} curve_point_t;

	key_t              key_mem [MAX_KEYS];
	logic [5:0]        cursor;
	logic [KC_W-1:0]   key_count;
	logic [DIM_W-1:0]  dim_mode;
	curve_point_t      pending_points [$];
	int                mismatch_count;

	// v0 + (v1 - v0) * num / den on magnitudes, truncated toward zero.
	function automatic logic signed [VALUE_W-1:0] blend(input logic signed [VALUE_W-1:0] v0,
			input logic signed [VALUE_W-1:0] v1, input longint unsigned num,
			input longint unsigned den);
		longint          base;
		longint          delta;
		longint          res;
		longint unsigned mag;
		longint unsigned part;
		base  = v0;
		delta = v1 - base;
		mag   = (delta < 0) ? -delta : delta;
		part  = (mag / den) * num + ((mag % den) * num) / den;
		res   = (delta < 0) ? base - longint'(part) : base + longint'(part);
		return res[VALUE_W-1:0];
	endfunction

	function automatic curve_point_t interpolate_sample(input logic [STAMP_W-1:0] t_in);
		int unsigned  kc, last, c, t, t0, t1, lo, hi, te, num;
		logic         bad_time, ran_past, degenerate;
		curve_point_t p;
		kc = key_count;
		if (kc < 2) kc = 2;
		if (kc > MAX_KEYS) kc = MAX_KEYS;
		last = kc - 2;
		t = t_in;
		bad_time = 1'b0;
		if (t > STAMP_ONE) begin
			t = STAMP_ONE;
			bad_time = 1'b1;
		end
		// The cursor first saturates, then falls back to key 0 if it already lies
		// beyond the sample time, and then walks forward.
		c = cursor;
		if (c > last) c = last;
		if (key_mem[c].stamp > t) c = 0;
		while (key_mem[c + 1].stamp < t && c != last) c++;
		ran_past = key_mem[c + 1].stamp < t;
		t0 = key_mem[c].stamp;
		t1 = key_mem[c + 1].stamp;
		degenerate = (t0 == t1);
		if (degenerate) begin
			p.x = key_mem[c].x;
			p.y = key_mem[c].y;
			p.z = key_mem[c].z;
		end else begin
			lo = (t0 < t1) ? t0 : t1;
			hi = (t0 < t1) ? t1 : t0;
			te = t;
			if (te < lo) begin
				te = lo;
				bad_time = 1'b1;
			end
			if (te > hi) begin
				te = hi;
				bad_time = 1'b1;
			end
			num = (t0 < t1) ? te - t0 : t0 - te;
			p.x = blend(key_mem[c].x, key_mem[c + 1].x, num, hi - lo);
			p.y = blend(key_mem[c].y, key_mem[c + 1].y, num, hi - lo);
			p.z = blend(key_mem[c].z, key_mem[c + 1].z, num, hi - lo);
		end
		if (dim_mode != DIM_THREE) begin
			p.y = '0;
			p.z = '0;
		end
		p.seg = c[5:0];
		if (ran_past) p.err = ERR_PAST;
		else if (bad_time) p.err = ERR_TIME;
		else if (degenerate) p.err = ERR_DEGEN;
		else p.err = ERR_OK;
		return p;
	endfunction

	task automatic check_field(input string label, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, actual %0d", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		curve_point_t point;
		curve_point_t want;
		if (!arst_n) begin
			cursor = '0;
			key_count = KC_RESET;
			dim_mode = DIM_RESET;
			pending_points.delete();
			mismatch_count = 0;
			outstanding <= 0;
			failures <= 0;
		end else begin
			if (done) begin
				if (pending_points.size() == 0) begin
					$display("%0t ns: result expected none, actual x %0d segment %0d error %0d",
						$time, out_x, segment, error_code);
					mismatch_count++;
				end else begin
					want = pending_points.pop_front();
					check_field("out_x", want.x, out_x);
					check_field("out_y", want.y, out_y);
					check_field("out_z", want.z, out_z);
					check_field("segment", want.seg, segment);
					check_field("error_code", want.err, error_code);
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_KEY_COUNT) key_count = pwdata[KC_W-1:0];
				else if (paddr == ADDR_DIM_MODE) dim_mode = pwdata[DIM_W-1:0];
			end
			if (start && !busy) begin
				case (action)
					ACT_WRITE: key_mem[key_slot] = '{stamp: key_stamp, x: key_value_x,
						y: key_value_y, z: key_value_z};
					ACT_SAMPLE: begin
						point = interpolate_sample(sample_time);
						cursor = point.seg;
						pending_points.push_back(point);
					end
					ACT_RESTART: cursor = '0;
					default: ;
				endcase
			end
			outstanding <= pending_points.size();
			failures <= mismatch_count;
		end
	end

endmodule

/* tb/tb_piecewise_linear_curve_sampler.sv */
`timescale 1ns / 1ps
module tb_piecewise_linear_curve_sampler;
	import plcs_pkg::*;

	// The only action code the package leaves unnamed; the block drops it.
	localparam logic [1:0] ACT_IGNORED = 2'd3;

	localparam logic [2:0] ADDR_KEY_COUNT = {REG_KEY_COUNT, 2'b00};
	localparam logic [2:0] ADDR_DIM_MODE  = {REG_DIM_MODE, 2'b00};

	localparam int STAMP_MAX      = (1 << STAMP_W) - 1;
	localparam int DIRECTED_ITEMS = 21;
	localparam int RANDOM_ITEMS   = 1250;
	// Idling stops once this many transfers have gone by.
	localparam int LATE_MARK      = DIRECTED_ITEMS + RANDOM_ITEMS - 150;
	// Quiet time at the end, after the last result, in which no stray result may appear.
	localparam int DRAIN_CYCLES   = 150;
	// Cycles without any transfer on any channel before the run is abandoned.
	localparam int QUIET_LIMIT    = 4000;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [1:0]                action;
	logic [5:0]                key_slot;
	logic [STAMP_W-1:0]        key_stamp;
	logic signed [VALUE_W-1:0] key_value_x;
	logic signed [VALUE_W-1:0] key_value_y;
	logic signed [VALUE_W-1:0] key_value_z;
	logic [STAMP_W-1:0]        sample_time;
	logic                      done;
	logic signed [VALUE_W-1:0] out_x;
	logic signed [VALUE_W-1:0] out_y;
	logic signed [VALUE_W-1:0] out_z;
	logic [5:0]                segment;
	logic [1:0]                error_code;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [2:0]                paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;

	int                        outstanding;
	int                        failures;

	// Stimulus bookkeeping: whether the sender may idle, how many transfers that
	// reach the block's state have gone by, and the key times last written, so that
	// samples can be aimed at or next to existing keys.
	bit                        idle_on;
	int                        items_sent;
	int                        quiet_cycles = 0;
	logic [STAMP_W-1:0]        stamp_copy [MAX_KEYS];
	int                        kc_extremes [6] = '{0, 1, 64, 65, 127, 2};

	piecewise_linear_curve_sampler dut (.*);

	plcs_curve_checker checker_i (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// One command transfer. The sender may first drop start for an idle gap. It
	// then holds the command until the edge at which busy is low. When no gap is
	// taken, start simply stays high into the next command, so it is never
	// lowered and raised in the same time step.
	task automatic send_cmd(input logic [1:0] act, input logic [5:0] slot,
			input logic [STAMP_W-1:0] stamp, input logic [31:0] vx, input logic [31:0] vy,
			input logic [31:0] vz, input logic [STAMP_W-1:0] when);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		key_slot <= slot;
		key_stamp <= stamp;
		key_value_x <= vx;
		key_value_y <= vy;
		key_value_z <= vz;
		sample_time <= when;
		do @(posedge clk); while (busy);
		if (act != ACT_IGNORED) items_sent++;
		if (act == ACT_WRITE) stamp_copy[slot] = stamp;
	endtask

	// A key write; the unused sample time carries random bits.
	task automatic put_key(input logic [5:0] slot, input logic [STAMP_W-1:0] stamp,
			input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
		send_cmd(ACT_WRITE, slot, stamp, vx, vy, vz, STAMP_W'($urandom));
	endtask

	// A sample, restart or ignored command; the unused key fields carry random bits.
	task automatic send_bare(input logic [1:0] act, input logic [STAMP_W-1:0] when);
		send_cmd(act, 6'($urandom), STAMP_W'($urandom), $urandom, $urandom, $urandom, when);
	endtask

	// Register write: a setup phase, then an access phase that ends at the edge
	// where pready is high, then an idle bus before the next write.
	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait until every sample has delivered its result. A write
	// or restart produces nothing and completes in its own cycle, so it needs no
	// wait of its own before the registers may be touched.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Key values: full-scale extremes, small values near zero, and raw bits.
	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 1 << 20)) - 32'd524288;
			default: return $urandom;
		endcase
	endfunction

	// Sample times: mostly inside [0, 1.0], often exactly on a key or one step
	// beside it, sometimes above 1.0 up to the top of the field.
	function automatic logic [STAMP_W-1:0] pick_time(input int n);
		int k;
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 9))
			0, 1: return stamp_copy[k];
			2: return ($urandom_range(0, 1) != 0) ? stamp_copy[k] + 1'b1 : stamp_copy[k] - 1'b1;
			3: return STAMP_W'($urandom_range(STAMP_ONE + 1, STAMP_MAX));
			4: return ($urandom_range(0, 1) != 0) ? STAMP_ONE : '0;
			default: return STAMP_W'($urandom_range(0, STAMP_ONE));
		endcase
	endfunction

	// Fill slots 0..n-1. Most curves are well formed: key times rise from 0 to 1.0,
	// with an occasional repeated time. Some start late and may end early, so that
	// samples fall before the first key or past the last one. A few are random
	// times, out of order and sometimes above 1.0.
	task automatic fill_curve(input int n);
		int mode, avg, i, next;
		logic [STAMP_W-1:0] s;
		mode = $urandom_range(0, 19);
		avg = STAMP_ONE / (n - 1);
		s = (mode < 14) ? '0 : STAMP_W'($urandom_range(0, 20000));
		for (i = 0; i < n; i++) begin
			if (mode >= 17) s = STAMP_W'($urandom_range(0, (mode == 19) ? STAMP_MAX : STAMP_ONE));
			else if (i == n - 1 && mode < 14) s = STAMP_ONE;
			put_key(i[5:0], s, rand_value(), rand_value(), rand_value());
			if (mode < 17) begin
				next = s + (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2 * avg));
				s = (next > STAMP_ONE) ? STAMP_ONE : STAMP_W'(next);
			end
		end
	endtask

	// Watchdog: any transfer on the command, result or register channel restarts
	// the count. A hung block or a lost result ends the run here.
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("piecewise_linear_curve_sampler: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		int phase, eff, kc_raw, dim_sel, steps, r;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_WRITE;
		key_slot = '0;
		key_stamp = '0;
		key_value_x = '0;
		key_value_y = '0;
		key_value_z = '0;
		sample_time = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		items_sent = 0;
		idle_on = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first with the reset registers (two keys, x only).
		// A full-scale swing from the most negative to the most positive value
		// checks that the quotient never overflows.
		put_key(6'd0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		put_key(6'd1, STAMP_ONE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		send_bare(ACT_SAMPLE, '0);
		send_bare(ACT_SAMPLE, STAMP_ONE);
		send_bare(ACT_SAMPLE, STAMP_W'(32768));
		// Time above 1.0: flagged and clamped.
		send_bare(ACT_SAMPLE, STAMP_W'(STAMP_MAX));
		send_bare(ACT_RESTART, '0);
		send_bare(ACT_IGNORED, STAMP_W'($urandom));

		// Four keys in three dimensions, the first two at the same time.
		wait_idle();
		cfg_write(ADDR_KEY_COUNT, 32'd4);
		cfg_write(ADDR_DIM_MODE, 32'(DIM_THREE));
		put_key(6'd0, STAMP_W'(1000), rand_value(), rand_value(), rand_value());
		put_key(6'd1, STAMP_W'(1000), rand_value(), rand_value(), rand_value());
		put_key(6'd2, STAMP_W'(20000), rand_value(), rand_value(), rand_value());
		put_key(6'd3, STAMP_W'(30000), rand_value(), rand_value(), rand_value());
		// Before the first key, then on the degenerate first segment, then a walk
		// forward over two keys, then past the last key.
		send_bare(ACT_SAMPLE, STAMP_W'(500));
		send_bare(ACT_SAMPLE, STAMP_W'(1000));
		send_bare(ACT_SAMPLE, STAMP_W'(25000));
		send_bare(ACT_SAMPLE, STAMP_W'(40000));

		// The cursor now sits at key 2; shrinking the table forces it to saturate.
		wait_idle();
		cfg_write(ADDR_KEY_COUNT, 32'd2);
		send_bare(ACT_SAMPLE, STAMP_W'(1000));

		// Keys out of order: the first key lies after the second.
		put_key(6'd0, STAMP_W'(50000), rand_value(), rand_value(), rand_value());
		put_key(6'd1, STAMP_W'(20000), rand_value(), rand_value(), rand_value());
		send_bare(ACT_SAMPLE, STAMP_W'(10000));
		send_bare(ACT_SAMPLE, STAMP_W'(60000));
		// The top slot with the largest stamp the field can carry.
		put_key(6'd63, STAMP_W'(STAMP_MAX), 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);

		// Random phases. Each one waits for all results, which also gives a pause
		// with nothing in flight, then picks new register settings, rebuilds the
		// part of the table that the key count reaches, and runs a mix of samples,
		// restarts, stray key writes and ignored commands. The first six phases
		// walk through the extreme settings, clamped key counts among them.
		phase = 0;
		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			wait_idle();
			idle_on = (items_sent < LATE_MARK) && ($urandom_range(0, 3) != 0);
			if (phase < 6) begin
				kc_raw = kc_extremes[phase];
				dim_sel = (phase % 4 == 0) ? 0 : (phase % 2 == 0) ? DIM_THREE : phase % 4;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10) kc_raw = kc_extremes[$urandom_range(0, 5)];
				else if (r < 80) kc_raw = $urandom_range(2, 12);
				else kc_raw = $urandom_range(13, MAX_KEYS);
				dim_sel = $urandom_range(0, 3);
			end
			// Upper data bits are random; only the register's own width counts.
			if ($urandom_range(0, 1) != 0) begin
				cfg_write(ADDR_KEY_COUNT, ($urandom & ~32'h7F) | 32'(kc_raw));
				cfg_write(ADDR_DIM_MODE, ($urandom & ~32'h3) | 32'(dim_sel));
			end else begin
				cfg_write(ADDR_DIM_MODE, ($urandom & ~32'h3) | 32'(dim_sel));
				cfg_write(ADDR_KEY_COUNT, ($urandom & ~32'h7F) | 32'(kc_raw));
			end
			eff = (kc_raw < 2) ? 2 : (kc_raw > MAX_KEYS) ? MAX_KEYS : kc_raw;
			fill_curve(eff);
			steps = $urandom_range(20, 80);
			repeat (steps) begin
				r = $urandom_range(0, 99);
				if (r < 68) begin
					send_bare(ACT_SAMPLE, pick_time(eff));
				end else if (r < 78) begin
					send_bare(ACT_RESTART, STAMP_W'($urandom));
				end else if (r < 92) begin
					put_key(6'($urandom), ($urandom_range(0, 3) == 0) ? STAMP_W'($urandom)
						: STAMP_W'($urandom_range(0, STAMP_ONE)),
						rand_value(), rand_value(), rand_value());
				end else begin
					send_bare(ACT_IGNORED, STAMP_W'($urandom));
				end
			end
			phase++;
		end

		// Drain: everything outstanding must arrive, and nothing may follow it.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("piecewise_linear_curve_sampler: match");
		else
			$display("piecewise_linear_curve_sampler: mismatch");
		$finish;
	end

endmodule
